### hw/rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the audio soft clipper.
// ----------------------------------------------------------------------------
package asc_pkg;

  typedef enum logic [2:0] {
    CURVE_BYPASS = 3'd0,
    CURVE_SCURVE = 3'd1,
    CURVE_KNEE   = 3'd2,
    CURVE_CUBIC  = 3'd3,
    CURVE_PWQ    = 3'd4
  } curve_t;

  // register byte addresses
  localparam logic [3:0] ADDR_CURVE    = 4'h0;
  localparam logic [3:0] ADDR_IN_GAIN  = 4'h4;
  localparam logic [3:0] ADDR_OUT_GAIN = 4'h8;

  localparam int XW    = 18;   // Q2.15 intermediate
  localparam int NUMW  = 40;   // divider dividend
  localparam int DENW  = 23;   // divider divisor
  localparam int QW    = 17;   // divider quotient
  localparam int P2W   = 39;   // cubic product
  localparam int DIV_STAGES = QW;

  // items riding alongside the divider
  typedef struct packed {
    logic                   block_end;
    curve_t                 mode;
    logic signed [XW-1:0]   x;
    logic signed [P2W-1:0]  p2;
    logic                   neg;
  } side_t;

endpackage

### hw/rtl/audio_soft_clipper_unit.sv
// Pipeline: 3 front stages, 17 divider stages, 3 back stages.
//   The 17-stage quotient pipeline sets depth.
// Throughput: one transaction per cycle while the result register is not stalled.
// The whole pipeline holds while the result register is stalled.
// Reset (synchronous, rst_n low): all stages empty, curve_mode = 1,
//   in_gain = out_gain = 4096 (unity).
// ----------------------------------------------------------------------------
// audio_soft_clipper_unit
// Input gain, selectable soft-clip curve, output gain, 16-bit saturation.
// ----------------------------------------------------------------------------
module audio_soft_clipper_unit import asc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  input  logic               in_block_end,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  output logic               out_block_end_out,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- registers ----------------
  logic [2:0]  curve_r;
  logic [15:0] in_gain_r;
  logic [15:0] out_gain_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r    <= 3'd1;
      in_gain_r  <= 16'd4096;
      out_gain_r <= 16'd4096;
    end else if (wr_en) begin
      case ({paddr[3:2], 2'b00})
        ADDR_CURVE:    curve_r    <= pwdata[2:0];
        ADDR_IN_GAIN:  in_gain_r  <= pwdata[15:0];
        ADDR_OUT_GAIN: out_gain_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case ({paddr[3:2], 2'b00})
      ADDR_CURVE:    prdata = {29'd0, curve_r};
      ADDR_IN_GAIN:  prdata = {16'd0, in_gain_r};
      ADDR_OUT_GAIN: prdata = {16'd0, out_gain_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Whole pipeline moves together unless the held result is stalled.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  curve_t mode;
  assign mode = curve_t'(curve_r);

  // ---------------- stage 1: input gain product ----------------
  logic               v1_r, be1_r;
  logic signed [32:0] prod1_r;

  // ---------------- stage 2: round and clamp to Q2.15 ----------------
  logic               v2_r, be2_r;
  logic signed [XW-1:0] x2_r;
  logic signed [33:0] rnd1;
  logic signed [21:0] sh1;
  logic signed [XW-1:0] x2_nxt;

  assign rnd1 = {prod1_r[32], prod1_r} + 34'sd2048;
  assign sh1  = rnd1[33:12];

  always_comb begin
    if (sh1 > 22'sd131071)       x2_nxt = 18'sd131071;
    else if (sh1 < -22'sd131072) x2_nxt = -18'sd131072;
    else                         x2_nxt = sh1[XW-1:0];
  end

  // ---------------- stage 3: shared squarer ----------------
  // cubic squares |x|, knee squares 4d, quadratic squares 2 - 3|x|
  logic               v3_r, be3_r;
  logic signed [XW-1:0] x3_r;
  logic [37:0]        p3_r;
  logic [XW-1:0]      a2;
  logic [16:0]        d2;
  logic signed [19:0] t2;
  logic [18:0]        mop;

  assign a2 = x2_r[XW-1] ? XW'(-x2_r) : x2_r;
  assign d2 = (x2_r >= 18'sd24576) ? 17'(x2_r - 18'sd24576) : 17'd0;
  assign t2 = 20'sd65536 - 20'($signed({2'b00, a2}) * 20'sd3);

  always_comb begin
    case (mode)
      CURVE_CUBIC: mop = {1'b0, a2};
      CURVE_KNEE:  mop = {d2, 2'b00};
      CURVE_PWQ:   mop = (t2 > 20'sd0) ? t2[18:0] : 19'd0;
      default:     mop = 19'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      be1_r   <= in_block_end;
      prod1_r <= 33'(in_sample_in * $signed({1'b0, in_gain_r}));
      be2_r   <= be1_r;
      x2_r    <= x2_nxt;
      be3_r   <= be2_r;
      x3_r    <= x2_r;
      p3_r    <= mop * mop;
    end
  end

  // ---------------- stage 4: cubic product, divider operands ----------------
  logic [22:0]        sq;
  logic [XW-1:0]      a3;
  logic [16:0]        d3;
  logic [NUMW-1:0]    num4;
  logic [DENW-1:0]    den4;
  side_t              side4;

  assign sq = p3_r[37:15];
  assign a3 = x3_r[XW-1] ? XW'(-x3_r) : x3_r;
  assign d3 = (x3_r >= 18'sd24576) ? 17'(x3_r - 18'sd24576) : 17'd0;

  always_comb begin
    case (mode)
      CURVE_SCURVE: begin
        num4 = {6'd0, a3, 16'd0};
        den4 = 23'd32768 + DENW'(a3);
      end
      CURVE_KNEE: begin
        num4 = {8'd0, d3, 15'd0};
        den4 = 23'd32768 + sq;
      end
      CURVE_PWQ: begin
        num4 = NUMW'(17'd98304 - sq[16:0]);
        den4 = 23'd3;
      end
      default: begin
        num4 = '0;
        den4 = 23'd1;
      end
    endcase
    side4.block_end = be3_r;
    side4.mode      = mode;
    side4.x         = x3_r;
    side4.p2        = $signed({1'b0, sq[19:0]}) * x3_r;
    side4.neg       = x3_r[XW-1];
  end

  logic           dv_vld;
  logic [QW-1:0]  dv_q;
  side_t          dv_sb;

  asc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v3_r),
    .in_num   (num4),
    .in_den   (den4),
    .in_side  (side4),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_sb)
  );

  // ---------------- stage 5: curve select and Q2.15 clamp ----------------
  logic                 v5_r, be5_r;
  logic signed [XW-1:0] y5_r;
  logic signed [25:0]   yw;
  logic signed [25:0]   qs;
  logic signed [25:0]   cub;
  logic [XW-1:0]        a5;
  logic signed [XW-1:0] y5_nxt;

  assign a5  = dv_sb.x[XW-1] ? XW'(-dv_sb.x) : dv_sb.x;
  assign qs  = dv_sb.neg ? -$signed({9'd0, dv_q}) : $signed({9'd0, dv_q});
  // floor((3x - floor(x^3)) / 2)
  assign cub = (26'(dv_sb.x) * 26'sd3 - 26'(dv_sb.p2 >>> 15)) >>> 1;

  always_comb begin
    case (dv_sb.mode)
      CURVE_SCURVE: yw = qs;
      CURVE_KNEE:   yw = (dv_sb.x < 18'sd24576) ? 26'(dv_sb.x)
                                                : 26'sd24576 + $signed({9'd0, dv_q});
      CURVE_CUBIC:  yw = cub;
      CURVE_PWQ: begin
        if (a5 < 18'd10923)      yw = 26'(dv_sb.x) * 26'sd2;
        else if (a5 < 18'd21845) yw = qs;
        else                     yw = dv_sb.neg ? -26'sd32768 : 26'sd32768;
      end
      default:      yw = 26'(dv_sb.x);
    endcase
    if (yw > 26'sd131071)       y5_nxt = 18'sd131071;
    else if (yw < -26'sd131072) y5_nxt = -18'sd131072;
    else                        y5_nxt = yw[XW-1:0];
  end

  // ---------------- stage 6: output gain product ----------------
  logic               v6_r, be6_r;
  logic signed [34:0] prod6_r;

  // ---------------- stage 7: round, saturate, result register ----------------
  logic signed [35:0] rnd6;
  logic signed [23:0] sh6;
  logic signed [15:0] o_nxt;

  assign rnd6 = {prod6_r[34], prod6_r} + 36'sd2048;
  assign sh6  = rnd6[35:12];

  always_comb begin
    if (sh6 > 24'sd32767)       o_nxt = 16'sd32767;
    else if (sh6 < -24'sd32768) o_nxt = -16'sd32768;
    else                        o_nxt = sh6[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v5_r      <= dv_vld;
      v6_r      <= v5_r;
      out_valid <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      be5_r             <= dv_sb.block_end;
      y5_r              <= y5_nxt;
      be6_r             <= be5_r;
      prod6_r           <= 35'(y5_r * $signed({1'b0, out_gain_r}));
      out_block_end_out <= be6_r;
      out_sample_out    <= o_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !v5_r)
    else $error("pipeline not empty after reset");
  a_curve_wr: assert property (@(posedge clk) disable iff (!rst_n)
      wr_en && paddr[3:2] == 2'd0 |=> curve_r == $past(pwdata[2:0]))
    else $error("curve register write lost");
  a_div_to_y: assert property (@(posedge clk) disable iff (!rst_n)
      adv && dv_vld |=> v5_r)
    else $error("divider result dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      !adv |=> $stable(v6_r) && $stable(v5_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

### hw/rtl/asc_div_pipe.sv
// ----------------------------------------------------------------------------
// asc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module asc_div_pipe import asc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [NUMW-1:0]   in_num,
  input  logic [DENW-1:0]   in_den,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [QW-1:0]     out_q,
  output side_t             out_side
);

  logic [NUMW-1:0] rem_r [DIV_STAGES];
  logic [DENW-1:0] den_r [DIV_STAGES];
  logic [QW-1:0]   q_r   [DIV_STAGES];
  side_t           sb_r  [DIV_STAGES];
  logic            vld_r [DIV_STAGES];

  logic [NUMW-1:0] rem_nxt [DIV_STAGES];
  logic [QW-1:0]   q_nxt   [DIV_STAGES];

  always_comb begin
    logic [NUMW-1:0] rin;
    logic [DENW-1:0] din;
    logic [QW-1:0]   qin;
    logic [NUMW:0]   trial;
    for (int j = 0; j < DIV_STAGES; j++) begin
      rin = (j == 0) ? in_num : rem_r[(j == 0) ? 0 : j-1];
      din = (j == 0) ? in_den : den_r[(j == 0) ? 0 : j-1];
      qin = (j == 0) ? '0 : q_r[(j == 0) ? 0 : j-1];
      trial = {1'b0, rin} - ({{(NUMW+1-DENW){1'b0}}, din} << (QW-1-j));
      if (!trial[NUMW]) begin
        rem_nxt[j] = trial[NUMW-1:0];
        q_nxt[j]   = qin | (QW'(1) << (QW-1-j));
      end else begin
        rem_nxt[j] = rin;
        q_nxt[j]   = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) vld_r[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < DIV_STAGES; j++) vld_r[j] <= (j == 0) ? in_vld : vld_r[(j == 0) ? 0 : j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        den_r[j] <= (j == 0) ? in_den : den_r[(j == 0) ? 0 : j-1];
        sb_r[j]  <= (j == 0) ? in_side : sb_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_q    = q_r[DIV_STAGES-1];
  assign out_side = sb_r[DIV_STAGES-1];

endmodule
